@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the goal tracker RTL.
// Needs a clk and an rst_n signal in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ppgt_pkg.sv @@
// Types, codes and constant tables of the pure pursuit goal tracker.
// No dependencies; every RTL module of the block imports it.
package ppgt_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_POSE   = 2'd2;

    localparam int CFG_W = 24;
    localparam logic [2:0] CFG_MAX_SPEED     = 3'd0;
    localparam logic [2:0] CFG_MAX_TURN_RATE = 3'd1;
    localparam logic [2:0] CFG_STEER_GAIN    = 3'd2;
    localparam logic [2:0] CFG_LOOKAHEAD     = 3'd3;
    localparam logic [2:0] CFG_FINISH_RADIUS = 3'd4;

    localparam logic [15:0] MAX_SPEED_RST     = 16'd1000;
    localparam logic [14:0] MAX_TURN_RATE_RST = 15'd8192;
    localparam logic [15:0] STEER_GAIN_RST    = 16'd256;
    localparam logic [23:0] LOOKAHEAD_RST     = 24'd65536;
    localparam logic [15:0] FINISH_RADIUS_RST = 16'd1311;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic               final_point;
    } item_t;

    typedef struct packed {
        logic [15:0]        speed_cmd;
        logic signed [15:0] turn_cmd;
        logic               path_end;
        logic               lap_end;
        logic [10:0]        goal_slot;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FR2, ST_FR2_W, ST_FIN, ST_FIN_W, ST_POSE, ST_LA2, ST_LA2_W,
        ST_GD, ST_GD_W, ST_FG, ST_SCAN_RD, ST_SCAN_GO, ST_SCAN_W, ST_SCAN_END,
        ST_ADV, ST_ADV_GO, ST_ADV_W, ST_ADV_END, ST_GOAL, ST_CHECK, ST_CORD,
        ST_CORD_W, ST_TURN, ST_CLAMP, ST_RESULT
    } gt_state_t;

    typedef enum logic [1:0] {
        DP_IDLE, DP_SQX, DP_SQY, DP_SUM
    } dist_phase_t;

    function automatic logic [15:0] atan_lut(input logic [4:0] i);
        logic [15:0] a;
        case (i)
            5'd0:    a = 16'd8192;
            5'd1:    a = 16'd4836;
            5'd2:    a = 16'd2555;
            5'd3:    a = 16'd1297;
            5'd4:    a = 16'd651;
            5'd5:    a = 16'd326;
            5'd6:    a = 16'd163;
            5'd7:    a = 16'd81;
            5'd8:    a = 16'd41;
            5'd9:    a = 16'd20;
            5'd10:   a = 16'd10;
            5'd11:   a = 16'd5;
            5'd12:   a = 16'd3;
            5'd13:   a = 16'd1;
            5'd14:   a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

@@ hw/rtl/ppgt_dist.sv @@
// Squared distance unit: one 32x32 multiplier used twice, then a saturating add.
// Depends on ppgt_pkg; the result is registered through the SQX, SQY and SUM phases after start.
module ppgt_dist
    import ppgt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by,
    output logic               done,
    output logic [63:0]        d2
);

    dist_phase_t ph_reg;
    logic        done_reg;
    logic [31:0] mx_reg, my_reg;
    logic [63:0] sx_reg, sy_reg, d2_reg;

    logic signed [32:0] dx, dy;
    logic [32:0]        ux, uy;
    logic [31:0]        mul_op;
    logic [63:0]        prod;
    logic [64:0]        sum;

    always_comb
    begin
        dx     = {ax[31], ax} - {bx[31], bx};
        dy     = {ay[31], ay} - {by[31], by};
        ux     = dx[32] ? 33'(-dx) : 33'(dx);
        uy     = dy[32] ? 33'(-dy) : 33'(dy);
        mul_op = (ph_reg == DP_SQX) ? mx_reg : my_reg;
        prod   = 64'(mul_op) * 64'(mul_op);
        sum    = {1'b0, sx_reg} + {1'b0, sy_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= DP_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (ph_reg == DP_SUM);
            case (ph_reg)
                DP_SQX:  ph_reg <= DP_SQY;
                DP_SQY:  ph_reg <= DP_SUM;
                DP_SUM:  ph_reg <= DP_IDLE;
                default: ph_reg <= start ? DP_SQX : DP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mx_reg <= ux[31:0];
            my_reg <= uy[31:0];
        end
        if (ph_reg == DP_SQX)
        begin
            sx_reg <= prod;
        end
        if (ph_reg == DP_SQY)
        begin
            sy_reg <= prod;
        end
        if (ph_reg == DP_SUM)
        begin
            d2_reg <= sum[64] ? {64{1'b1}} : sum[63:0];
        end
    end

    assign done = done_reg;
    assign d2   = d2_reg;

endmodule

@@ hw/rtl/ppgt_cordic.sv @@
// CORDIC vectoring unit that gives the bearing of a vector, one rotation a cycle.
// Depends on ppgt_pkg for the arctangent table and on assert_macros.svh.
`include "assert_macros.svh"
module ppgt_cordic
    import ppgt_pkg::*;
#(
    parameter int ITERS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] dx,
    input  logic signed [32:0] dy,
    output logic               done,
    output logic [15:0]        z
);

    localparam int IW = $clog2(ITERS);

    logic               run_reg, done_reg;
    logic [IW-1:0]      i_reg;
    logic signed [35:0] x_reg, y_reg;
    logic [15:0]        z_reg;

    logic signed [35:0] xs, ys, ex, ey;
    logic [15:0]        ang;
    logic               last;

    always_comb
    begin
        ex   = 36'(dx);
        ey   = 36'(dy);
        xs   = x_reg >>> i_reg;
        ys   = y_reg >>> i_reg;
        ang  = atan_lut(5'(i_reg));
        last = (i_reg == IW'(ITERS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= !(dx == 33'sd0 && dy == 33'sd0);
                done_reg <= (dx == 33'sd0 && dy == 33'sd0);
            end
            else if (run_reg && last)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg <= '0;
            if (dx < 33'sd0)
            begin
                x_reg <= -ex;
                y_reg <= -ey;
                z_reg <= 16'h8000;
            end
            else
            begin
                x_reg <= ex;
                y_reg <= ey;
                z_reg <= 16'd0;
            end
        end
        else if (run_reg)
        begin
            i_reg <= i_reg + IW'(1);
            if (y_reg > 36'sd0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
        end
    end

    assign done = done_reg;
    assign z    = z_reg;

    `ASSERT_NEXT(a_cord_finish, run_reg && last && !start, done_reg && !run_reg, "CORDIC did not finish")
    `ASSERT_CLK(a_cord_excl, !(run_reg && done_reg), "CORDIC done while still rotating")

endmodule

@@ hw/rtl/pure_pursuit_goal_tracker.sv @@
// Pure pursuit goal tracker: path store, sequencer, and result register.
// Depends on ppgt_pkg, ppgt_dist, ppgt_cordic and assert_macros.svh.
//
// A clear beat or a plain append beat is taken in the idle state; an append beat
// that carries the final point flag also runs the finish radius check. When the path
// holds more than one point, a pose beat runs through one shared squared-distance
// unit: a nearest-point scan and a lookahead advance when the goal lies within the
// lookahead, twice when a lap closes, then the CORDIC bearing and the turn. The block
// takes no beat while a pose is in work; a finished result waits in the output
// register.
`include "assert_macros.svh"
module pure_pursuit_goal_tracker
    import ppgt_pkg::*;
#(
    parameter int PATH_DEPTH   = 2048,
    parameter int CORDIC_ITERS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(PATH_DEPTH);
    localparam int CNT_W = $clog2(PATH_DEPTH + 1);

    gt_state_t state_reg, state_next;

    logic [15:0] max_speed_reg, steer_gain_reg, finish_radius_reg;
    logic [14:0] max_turn_rate_reg;
    logic [23:0] lookahead_reg;

    logic [CNT_W-1:0]   count_reg, j_reg;
    logic [IDX_W-1:0]   idx_reg, search_pos_reg, prior_pos_reg;
    logic               search_valid_reg, prior_valid_reg;
    logic               f_init_reg, f_done_reg, f_pend_reg, f_lap_reg;
    logic               mode_a_reg, second_reg, res_valid_reg;
    logic signed [31:0] goal_x_reg, goal_y_reg, start_x_reg, start_y_reg;
    logic signed [31:0] px_reg, py_reg, last_x_reg, last_y_reg;
    logic signed [15:0] hd_reg, err_reg;
    logic [47:0]        thr_reg;
    logic [63:0]        d_reg, rd_data_reg;
    logic [15:0]        speed_reg, turn_reg;
    logic [23:0]        mag_reg;
    result_t            res_reg;

    logic [63:0] mem [PATH_DEPTH];

    logic               accept, do_write, dist_start, dist_done, cord_start, cord_done;
    logic signed [31:0] da_x, da_y, db_x, db_y, rd_x, rd_y;
    logic [63:0]        dist_d2;
    logic [15:0]        cord_z, err_abs, three_q;
    logic [31:0]        gain_prod;
    logic [14:0]        clamp;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   idx_ext, prior_ext, last_idx;
    logic [17:0]        speed3;

    ppgt_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .ax    (da_x),
        .ay    (da_y),
        .bx    (db_x),
        .by    (db_y),
        .done  (dist_done),
        .d2    (dist_d2)
    );

    ppgt_cordic #(
        .ITERS (CORDIC_ITERS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .dx    ({goal_x_reg[31], goal_x_reg} - {px_reg[31], px_reg}),
        .dy    ({goal_y_reg[31], goal_y_reg} - {py_reg[31], py_reg}),
        .done  (cord_done),
        .z     (cord_z)
    );

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        accept     = item_valid && !item_stall;
        do_write   = accept && (item.cmd == CMD_APPEND) && (count_reg < CNT_W'(PATH_DEPTH));
        rd_x       = rd_data_reg[63:32];
        rd_y       = rd_data_reg[31:0];
        idx_ext    = CNT_W'(idx_reg);
        prior_ext  = CNT_W'(prior_pos_reg);
        last_idx   = count_reg - CNT_W'(1);
        rd_addr    = (state_reg == ST_SCAN_RD) ? j_reg[IDX_W-1:0] : idx_reg;
        speed3     = {2'b00, max_speed_reg} + {1'b0, max_speed_reg, 1'b0};
        three_q    = speed3[17:2];
        err_abs    = err_reg[15] ? 16'(-err_reg) : 16'(err_reg);
        gain_prod  = 32'(steer_gain_reg) * 32'(err_abs);
        clamp      = (mag_reg >= 24'(max_turn_rate_reg)) ? max_turn_rate_reg : mag_reg[14:0];
        dist_start = 1'b0;
        cord_start = 1'b0;
        da_x       = px_reg;
        da_y       = py_reg;
        db_x       = rd_x;
        db_y       = rd_y;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        CMD_APPEND: state_next = item.final_point ? ST_FR2 : ST_IDLE;
                        CMD_POSE:   state_next = ST_POSE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FR2:
            begin
                dist_start = 1'b1;
                da_x       = 32'(finish_radius_reg);
                da_y       = 32'sd0;
                db_x       = 32'sd0;
                db_y       = 32'sd0;
                state_next = ST_FR2_W;
            end
            ST_FR2_W:   state_next = dist_done ? ST_FIN : ST_FR2_W;
            ST_FIN:
            begin
                dist_start = 1'b1;
                da_x       = start_x_reg;
                da_y       = start_y_reg;
                db_x       = last_x_reg;
                db_y       = last_y_reg;
                state_next = ST_FIN_W;
            end
            ST_FIN_W:   state_next = dist_done ? ST_IDLE : ST_FIN_W;
            ST_POSE:    state_next = (count_reg > CNT_W'(1)) ? ST_LA2 : ST_RESULT;
            ST_LA2:
            begin
                dist_start = 1'b1;
                da_x       = 32'(lookahead_reg);
                da_y       = 32'sd0;
                db_x       = 32'sd0;
                db_y       = 32'sd0;
                state_next = ST_LA2_W;
            end
            ST_LA2_W:   state_next = dist_done ? ST_GD : ST_LA2_W;
            ST_GD:
            begin
                dist_start = 1'b1;
                db_x       = goal_x_reg;
                db_y       = goal_y_reg;
                state_next = ST_GD_W;
            end
            ST_GD_W:
            begin
                if (dist_done)
                begin
                    state_next = (64'(thr_reg) > dist_d2) ? ST_FG : ST_CHECK;
                end
            end
            ST_FG:      state_next = ST_SCAN_RD;
            ST_SCAN_RD: state_next = (j_reg < count_reg) ? ST_SCAN_GO : ST_SCAN_END;
            ST_SCAN_GO:
            begin
                dist_start = 1'b1;
                state_next = ST_SCAN_W;
            end
            ST_SCAN_W:
            begin
                if (dist_done)
                begin
                    state_next = (d_reg < dist_d2) ? ST_SCAN_END : ST_SCAN_RD;
                end
            end
            ST_SCAN_END: state_next = ST_ADV;
            ST_ADV:     state_next = (idx_ext + CNT_W'(1) < count_reg) ? ST_ADV_GO : ST_ADV_END;
            ST_ADV_GO:
            begin
                dist_start = 1'b1;
                state_next = ST_ADV_W;
            end
            ST_ADV_W:
            begin
                if (dist_done)
                begin
                    state_next = (dist_d2 >= 64'(thr_reg)) ? ST_ADV_END : ST_ADV;
                end
            end
            ST_ADV_END: state_next = ST_GOAL;
            ST_GOAL:    state_next = second_reg ? ST_CORD : ST_CHECK;
            ST_CHECK:   state_next = (f_pend_reg && f_done_reg) ? ST_FG : ST_CORD;
            ST_CORD:
            begin
                cord_start = 1'b1;
                state_next = ST_CORD_W;
            end
            ST_CORD_W:  state_next = cord_done ? ST_TURN : ST_CORD_W;
            ST_TURN:    state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            max_speed_reg     <= MAX_SPEED_RST;
            max_turn_rate_reg <= MAX_TURN_RATE_RST;
            steer_gain_reg    <= STEER_GAIN_RST;
            lookahead_reg     <= LOOKAHEAD_RST;
            finish_radius_reg <= FINISH_RADIUS_RST;
            count_reg         <= '0;
            search_pos_reg    <= '0;
            search_valid_reg  <= 1'b0;
            prior_pos_reg     <= '0;
            prior_valid_reg   <= 1'b0;
            f_init_reg        <= 1'b0;
            f_done_reg        <= 1'b0;
            f_pend_reg        <= 1'b0;
            f_lap_reg         <= 1'b0;
            second_reg        <= 1'b0;
            res_valid_reg     <= 1'b0;
            goal_x_reg        <= '0;
            goal_y_reg        <= '0;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_SPEED:     max_speed_reg     <= cfg_data[15:0];
                    CFG_MAX_TURN_RATE: max_turn_rate_reg <= cfg_data[14:0];
                    CFG_STEER_GAIN:    steer_gain_reg    <= cfg_data[15:0];
                    CFG_LOOKAHEAD:     lookahead_reg     <= cfg_data[23:0];
                    CFG_FINISH_RADIUS: finish_radius_reg <= cfg_data[15:0];
                    default:           ;
                endcase
            end
            if (state_reg == ST_RESULT && (!res_valid_reg || !result_stall))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && item.cmd == CMD_CLEAR)
                    begin
                        count_reg <= '0;
                    end
                    if (do_write)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (accept && item.cmd == CMD_POSE && !f_init_reg)
                    begin
                        f_init_reg  <= 1'b1;
                        start_x_reg <= item.pos_x;
                        start_y_reg <= item.pos_y;
                        if (count_reg != '0)
                        begin
                            goal_x_reg <= last_x_reg;
                            goal_y_reg <= last_y_reg;
                        end
                    end
                end
                ST_FIN_W:
                begin
                    if (dist_done && dist_d2 < 64'(thr_reg))
                    begin
                        f_done_reg <= 1'b1;
                    end
                end
                ST_POSE:    second_reg <= 1'b0;
                ST_SCAN_END:
                begin
                    prior_pos_reg   <= idx_reg;
                    prior_valid_reg <= 1'b1;
                end
                ST_ADV_END:
                begin
                    f_pend_reg       <= (idx_ext == last_idx);
                    search_pos_reg   <= idx_reg;
                    search_valid_reg <= 1'b1;
                end
                ST_GOAL:
                begin
                    goal_x_reg <= rd_x;
                    goal_y_reg <= rd_y;
                end
                ST_CHECK:
                begin
                    if (f_pend_reg && f_done_reg)
                    begin
                        f_lap_reg        <= 1'b1;
                        search_valid_reg <= 1'b0;
                        second_reg       <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[IDX_W-1:0]] <= {item.pos_x, item.pos_y};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    px_reg <= item.pos_x;
                    py_reg <= item.pos_y;
                    hd_reg <= item.heading;
                end
                if (do_write)
                begin
                    last_x_reg <= item.pos_x;
                    last_y_reg <= item.pos_y;
                end
            end
            ST_FR2_W, ST_LA2_W:
            begin
                if (dist_done)
                begin
                    thr_reg <= dist_d2[47:0];
                end
            end
            ST_POSE:
            begin
                speed_reg <= 16'd0;
                turn_reg  <= 16'd0;
            end
            ST_FG:
            begin
                d_reg <= {64{1'b1}};
                if (!search_valid_reg || !prior_valid_reg || prior_ext >= count_reg)
                begin
                    mode_a_reg <= 1'b1;
                    j_reg      <= '0;
                    idx_reg    <= '0;
                end
                else
                begin
                    mode_a_reg <= 1'b0;
                    j_reg      <= prior_ext;
                    idx_reg    <= prior_pos_reg;
                end
            end
            ST_SCAN_W:
            begin
                if (dist_done)
                begin
                    if (d_reg < dist_d2)
                    begin
                        if (!mode_a_reg)
                        begin
                            idx_reg <= j_reg[IDX_W-1:0];
                        end
                    end
                    else
                    begin
                        d_reg <= dist_d2;
                        j_reg <= j_reg + CNT_W'(1);
                        if (mode_a_reg)
                        begin
                            idx_reg <= j_reg[IDX_W-1:0];
                        end
                    end
                end
            end
            ST_ADV_W:
            begin
                if (dist_done && dist_d2 < 64'(thr_reg))
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            ST_CHECK:   speed_reg <= f_pend_reg ? three_q : max_speed_reg;
            ST_CORD_W:
            begin
                if (cord_done)
                begin
                    err_reg <= cord_z - hd_reg;
                end
            end
            ST_TURN:    mag_reg <= gain_prod[31:8];
            ST_CLAMP:   turn_reg <= err_reg[15] ? 16'(-{1'b0, clamp}) : {1'b0, clamp};
            ST_RESULT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_reg.speed_cmd <= speed_reg;
                    res_reg.turn_cmd  <= turn_reg;
                    res_reg.path_end  <= f_pend_reg;
                    res_reg.lap_end   <= f_lap_reg;
                    res_reg.goal_slot <= search_valid_reg ? 11'(search_pos_reg) : 11'd0;
                end
            end
            default: ;
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `ASSERT_CLK(a_count_range, count_reg <= CNT_W'(PATH_DEPTH), "Path count beyond store depth")
    `ASSERT_CLK(a_dist_wait, !dist_done || state_reg == ST_FR2_W || state_reg == ST_FIN_W || state_reg == ST_LA2_W || state_reg == ST_GD_W || state_reg == ST_SCAN_W || state_reg == ST_ADV_W, "Distance result arrived outside a wait state")
    `ASSERT_CLK(a_lap_sticky, !$fell(f_lap_reg), "Lap flag cleared")
    `ASSERT_NEXT(a_pose_entry, accept && item.cmd == CMD_POSE, state_reg == ST_POSE, "Pose beat not started")

endmodule

@@ tb/pure_pursuit_goal_tracker_tb.sv @@
// Self-checking testbench of pure_pursuit_goal_tracker: path, pose and lap scenarios.
// It predicts every pose result internally and compares the result beats field by field.
// Depends on ppgt_pkg and the block's RTL only.
module pure_pursuit_goal_tracker_tb;
    import ppgt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 2048;
    localparam int ITERS = 16;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    item_t            item;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    pure_pursuit_goal_tracker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    item_t   pending_items[$];
    result_t expected_results[$];
    int      src_idle;
    int      snk_idle;
    bit      failed;
    int      generated;

    // Tracker state.
    longint      path_x[DEPTH];
    longint      path_y[DEPTH];
    int unsigned path_len;
    longint      goal_x, goal_y;
    int unsigned goal_idx;
    bit          goal_idx_ok;
    int unsigned near_idx;
    bit          near_idx_ok;
    longint      start_x, start_y;
    bit          have_start, loop_closed, at_path_end, lap_done;
    longint      speed_max, turn_max, gain, lookahead, finish_rad;

    int arctan_steps[ITERS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                41, 20, 10, 5, 3, 1, 1, 0};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] dist_sq(longint ax, longint ay, longint bx, longint by);
        longint       dx, dy;
        logic [63:0]  mx, my;
        logic [127:0] s;
        dx = ax - bx;
        dy = ay - by;
        mx = 64'((dx < 0) ? -dx : dx);
        my = 64'((dy < 0) ? -dy : dy);
        s = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        return (s > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic int bearing_to(longint dx, longint dy);
        longint x, y, nx;
        int     z;
        z = 0;
        x = dx;
        y = dy;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 32768 : -32768;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITERS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_steps[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_steps[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic void pick_goal(longint cx, longint cy);
        int unsigned n, idx;
        logic [63:0] d, t, reach;
        n = path_len;
        reach = lookahead * lookahead;
        if (!goal_idx_ok || !near_idx_ok || near_idx >= n)
        begin
            d = 64'hFFFF_FFFF_FFFF_FFFF;
            idx = 0;
            for (int unsigned j = 0; j < n; j++)
            begin
                t = dist_sq(cx, cy, path_x[j], path_y[j]);
                if (d < t)
                    break;
                d = t;
                idx = j;
            end
        end
        else
        begin
            idx = near_idx;
            d = dist_sq(cx, cy, path_x[idx], path_y[idx]);
            for (int unsigned j = idx + 1; j < n; j++)
            begin
                t = dist_sq(cx, cy, path_x[j], path_y[j]);
                if (d < t)
                begin
                    idx = j;
                    break;
                end
                d = t;
            end
        end
        near_idx = idx;
        near_idx_ok = 1'b1;
        while (idx + 1 < n)
        begin
            if (dist_sq(cx, cy, path_x[idx], path_y[idx]) >= reach)
                break;
            idx++;
        end
        at_path_end = (idx == n - 1);
        goal_x = path_x[idx];
        goal_y = path_y[idx];
        goal_idx = idx;
        goal_idx_ok = 1'b1;
    endfunction

    function automatic bit step_tracker(input item_t it, output result_t r);
        longint      px, py, mag;
        int          hd, err;
        logic [15:0] err16;
        px = longint'(it.pos_x);
        py = longint'(it.pos_y);
        hd = int'(it.heading);
        r = '0;
        if (it.cmd == CMD_CLEAR)
        begin
            path_len = 0;
            return 1'b0;
        end
        if (it.cmd == CMD_APPEND)
        begin
            if (path_len < DEPTH)
            begin
                path_x[path_len] = px;
                path_y[path_len] = py;
                path_len++;
            end
            if (it.final_point && path_len > 0 &&
                dist_sq(start_x, start_y, path_x[path_len-1], path_y[path_len-1])
                    < finish_rad * finish_rad)
                loop_closed = 1'b1;
            return 1'b0;
        end
        if (it.cmd != CMD_POSE)
            return 1'b0;
        if (!have_start)
        begin
            start_x = px;
            start_y = py;
            have_start = 1'b1;
            if (path_len > 0)
            begin
                goal_x = path_x[path_len-1];
                goal_y = path_y[path_len-1];
            end
        end
        if (path_len > 1)
        begin
            if (lookahead * lookahead > dist_sq(px, py, goal_x, goal_y))
                pick_goal(px, py);
            if (at_path_end)
            begin
                r.speed_cmd = 16'((speed_max * 3) >> 2);
                if (loop_closed)
                begin
                    lap_done = 1'b1;
                    goal_idx_ok = 1'b0;
                    pick_goal(px, py);
                end
            end
            else
                r.speed_cmd = 16'(speed_max);
            err16 = 16'(bearing_to(goal_x - px, goal_y - py) - hd);
            err = int'(signed'(err16));
            mag = (gain * ((err < 0) ? -err : err)) >> 8;
            if (mag >= turn_max)
                mag = turn_max;
            r.turn_cmd = 16'((err < 0) ? -mag : mag);
        end
        r.path_end = at_path_end;
        r.lap_end = lap_done;
        r.goal_slot = goal_idx_ok ? goal_idx[10:0] : '0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                if (step_tracker(item, r))
                    expected_results = {expected_results, r};
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= src_idle)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (result.speed_cmd !== e.speed_cmd)
                    begin
                        $error("speed_cmd expected %0d got %0d", e.speed_cmd, result.speed_cmd);
                        failed = 1'b1;
                    end
                    if (result.turn_cmd !== e.turn_cmd)
                    begin
                        $error("turn_cmd expected %0d got %0d", e.turn_cmd, result.turn_cmd);
                        failed = 1'b1;
                    end
                    if (result.path_end !== e.path_end)
                    begin
                        $error("path_end expected %0d got %0d", e.path_end, result.path_end);
                        failed = 1'b1;
                    end
                    if (result.lap_end !== e.lap_end)
                    begin
                        $error("lap_end expected %0d got %0d", e.lap_end, result.lap_end);
                        failed = 1'b1;
                    end
                    if (result.goal_slot !== e.goal_slot)
                    begin
                        $error("goal_slot expected %0d got %0d", e.goal_slot, result.goal_slot);
                        failed = 1'b1;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    function automatic void add_item(int cmd, longint x, longint y, int h, bit fin);
        item_t it;
        it.cmd = 2'(cmd);
        it.pos_x = 32'(x);
        it.pos_y = 32'(y);
        it.heading = 16'(h);
        it.final_point = fin;
        pending_items = {pending_items, it};
        generated++;
    endfunction

    function automatic void add_noise();
        add_item($urandom_range(0, 3), longint'(int'($urandom)), longint'(int'($urandom)),
                 $urandom, $urandom_range(0, 1));
    endfunction

    // A route out and back that may end next to the start position, then poses along it.
    function automatic void add_route();
        longint rx[16], ry[16];
        int     n, poses, j, step, offs;
        n = $urandom_range(2, 14);
        step = $urandom_range(8192, 262144);
        offs = $urandom_range(0, 1) ? step : -step;
        if ($urandom_range(99) < 75)
            add_item(CMD_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < n; k++)
        begin
            if (k < n / 2)
            begin
                rx[k] = k * step;
                ry[k] = $urandom_range(0, 2000);
            end
            else
            begin
                rx[k] = (n - 1 - k) * step;
                ry[k] = offs;
            end
            if (k == n - 1 && $urandom_range(99) < 60)
            begin
                rx[k] = $urandom_range(0, 1000) - 500;
                ry[k] = $urandom_range(0, 1000) - 500;
            end
            add_item(CMD_APPEND, rx[k], ry[k], $urandom, k == n - 1);
        end
        poses = $urandom_range(3, 9);
        j = 0;
        for (int k = 0; k < poses; k++)
        begin
            add_item(CMD_POSE, rx[j] + $urandom_range(0, step) - step / 2,
                     ry[j] + $urandom_range(0, step) - step / 2, $urandom, $urandom_range(0, 1));
            j = j + $urandom_range(0, 2);
            if (j >= n)
                j = n - 1;
        end
    endfunction

    task automatic write_regs(longint ms, longint tr, longint sg, longint la, longint fr);
        logic [2:0] idx [5];
        longint     val [5];
        idx = '{CFG_MAX_SPEED, CFG_MAX_TURN_RATE, CFG_STEER_GAIN, CFG_LOOKAHEAD,
                CFG_FINISH_RADIUS};
        val = '{ms, tr, sg, la, fr};
        for (int i = 0; i < 5; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= CFG_W'(val[i]);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        speed_max = ms & 16'hFFFF;
        turn_max = tr & 15'h7FFF;
        gain = sg & 16'hFFFF;
        lookahead = la & 24'hFF_FFFF;
        finish_rad = fr & 16'hFFFF;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() > 0 || item_valid || expected_results.size() > 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int stop;
        stop = generated + count;
        while (generated < stop)
        begin
            if ($urandom_range(99) < 15)
                add_noise();
            else
                add_route();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        failed = 1'b0;
        generated = 0;
        src_idle = 16;
        snk_idle = 58;
        path_len = 0;
        goal_x = 0;
        goal_y = 0;
        goal_idx = 0;
        goal_idx_ok = 1'b0;
        near_idx = 0;
        near_idx_ok = 1'b0;
        start_x = 0;
        start_y = 0;
        have_start = 1'b0;
        loop_closed = 1'b0;
        at_path_end = 1'b0;
        lap_done = 1'b0;
        speed_max = MAX_SPEED_RST;
        turn_max = MAX_TURN_RATE_RST;
        gain = STEER_GAIN_RST;
        lookahead = LOOKAHEAD_RST;
        finish_rad = FINISH_RADIUS_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        add_item(CMD_POSE, 0, 0, -32768, 0);
        add_item(CMD_APPEND, 32'h7FFF_FFFF, -32'sh8000_0000, 0, 0);
        add_item(CMD_POSE, -32'sh8000_0000, 32'h7FFF_FFFF, 32767, 1);
        add_item(CMD_CLEAR, -1, -1, -1, 1);
        add_item(3, -1, -1, -1, 1);
        add_item(CMD_APPEND, 65536, 0, 0, 0);
        add_item(CMD_APPEND, 131072, 0, 0, 0);
        add_item(CMD_APPEND, 196608, 65536, 0, 0);
        add_item(CMD_APPEND, 65536, 65536, 0, 0);
        add_item(CMD_APPEND, 200, -300, 0, 1);
        add_item(CMD_POSE, 0, 0, 0, 0);
        add_item(CMD_POSE, 70000, 1000, 16384, 0);
        add_item(CMD_POSE, 190000, 60000, -16384, 0);
        add_item(CMD_POSE, 0, 0, 32767, 0);
        add_item(CMD_POSE, -32'sh8000_0000, -32'sh8000_0000, -32768, 0);
        add_item(CMD_POSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        add_item(CMD_POSE, 196608, 65536, 0, 0);
        drain();

        write_regs(65535, 32767, 65535, 24'hFF_FFFF, 65535);
        random_phase(36);
        src_idle = 58;
        snk_idle = 16;
        write_regs(0, 0, 0, 0, 0);
        random_phase(36);
        src_idle = 0;
        snk_idle = 0;
        write_regs($urandom_range(0, 65535), $urandom_range(1, 32767), $urandom_range(0, 4096),
                   $urandom_range(20000, 400000), $urandom_range(500, 65535));
        random_phase(36);

        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
